// ===== hdl/tfn_pkg.sv =====
// tfn_pkg: shared types and widths for the triangle face normal unit
// no dependencies; every other file in hdl/ refers to it by scoped names

package tfn_pkg;

   // field widths of the words on the ports
   localparam int unsigned COORD_BITS  = 32;
   localparam int unsigned NORMAL_BITS = 16;
   localparam int unsigned FRAC_BITS   = NORMAL_BITS - 2;
   localparam int unsigned QUO_BITS    = FRAC_BITS + 1;

   // datapath widths
   localparam int unsigned EDGE_W     = COORD_BITS + 1;
   localparam int unsigned PROD_W     = 2 * COORD_BITS;
   localparam int unsigned P_W        = 2 * COORD_BITS + 2;
   localparam int unsigned MAG_W      = 2 * COORD_BITS + 1;
   localparam int unsigned NORM_STEPS = $clog2(MAG_W);
   localparam int unsigned R_BITS     = 31;
   localparam int unsigned SQ_W       = 2 * R_BITS;
   localparam int unsigned SUM_W      = 2 * R_BITS + 2;
   localparam int unsigned LEN_W      = SUM_W / 2;
   localparam int unsigned SQ_REM_W   = LEN_W + 2;
   localparam int unsigned DIV_W      = LEN_W + FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax;
      logic signed [COORD_BITS-1:0] ay;
      logic signed [COORD_BITS-1:0] az;
      logic signed [COORD_BITS-1:0] bx;
      logic signed [COORD_BITS-1:0] by_coord;
      logic signed [COORD_BITS-1:0] bz;
      logic signed [COORD_BITS-1:0] cx;
      logic signed [COORD_BITS-1:0] cy;
      logic signed [COORD_BITS-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [NORMAL_BITS-1:0] nx;
      logic signed [NORMAL_BITS-1:0] ny;
      logic signed [NORMAL_BITS-1:0] nz;
      logic                          degenerate;
   } rsp_type;

   // control that rides along with each triangle
   typedef struct packed {
      logic       valid;
      logic       degenerate;
      logic [2:0] neg;
   } tag_type;

   // what the square root cells carry past the root
   typedef struct packed {
      tag_type                 tag;
      logic [2:0][R_BITS-1:0] r;
   } sqc_type;

endpackage

// ===== hdl/tfn_norm_cell.sv =====
// tfn_norm_cell: one step of the block normalize shifter for three magnitudes
// depends on tfn_pkg

module tfn_norm_cell #(
   parameter int unsigned SHIFT = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  tfn_pkg::tag_type                      up_tag,
   input  logic [2:0][tfn_pkg::MAG_W-1:0]        up_mag,
   output tfn_pkg::tag_type                      dn_tag,
   output logic [2:0][tfn_pkg::MAG_W-1:0]        dn_mag
);

   logic [tfn_pkg::MAG_W-1:0]       any_w;
   logic                            top_clear;
   logic [2:0][tfn_pkg::MAG_W-1:0]  mag_in;
   logic [2:0][tfn_pkg::MAG_W-1:0]  mag_ff;
   tfn_pkg::tag_type                tag_ff;

   // shift all three by the same amount when the top bits are clear in all
   always_comb begin
      any_w     = up_mag[0] | up_mag[1] | up_mag[2];
      top_clear = ~|any_w[tfn_pkg::MAG_W-1 -: SHIFT];
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = top_clear ? (up_mag[i] << SHIFT) : up_mag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= up_tag;
      end
      if (advance) begin
         mag_ff <= mag_in;
      end
   end

   assign dn_tag = tag_ff;
   assign dn_mag = mag_ff;

endmodule

// ===== hdl/tfn_sqrt_cell.sv =====
// tfn_sqrt_cell: one digit of a pipelined integer square root
// depends on tfn_pkg

module tfn_sqrt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  tfn_pkg::sqc_type                  up_carry,
   input  logic [tfn_pkg::SQ_REM_W-1:0]      up_rem,
   input  logic [tfn_pkg::LEN_W-1:0]         up_root,
   input  logic [tfn_pkg::SUM_W-1:0]         up_rad,
   output tfn_pkg::sqc_type                  dn_carry,
   output logic [tfn_pkg::SQ_REM_W-1:0]      dn_rem,
   output logic [tfn_pkg::LEN_W-1:0]         dn_root,
   output logic [tfn_pkg::SUM_W-1:0]         dn_rad
);

   logic [tfn_pkg::SQ_REM_W-1:0] rem_sh;
   logic [tfn_pkg::SQ_REM_W-1:0] trial;
   logic                         take;
   logic [tfn_pkg::SQ_REM_W-1:0] rem_in, rem_ff;
   logic [tfn_pkg::LEN_W-1:0]    root_in, root_ff;
   logic [tfn_pkg::SUM_W-1:0]    rad_in, rad_ff;
   tfn_pkg::sqc_type             carry_ff;

   // bring down two radicand bits, try root*4+1
   always_comb begin
      rem_sh  = {up_rem[tfn_pkg::SQ_REM_W-3:0], up_rad[tfn_pkg::SUM_W-1 -: 2]};
      trial   = {up_root, 2'b01};
      take    = (rem_sh >= trial);
      rem_in  = take ? (rem_sh - trial) : rem_sh;
      root_in = {up_root[tfn_pkg::LEN_W-2:0], take};
      rad_in  = up_rad << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.tag <= '0;
      end else if (advance) begin
         carry_ff.tag <= up_carry.tag;
      end
      if (advance) begin
         carry_ff.r <= up_carry.r;
         rem_ff     <= rem_in;
         root_ff    <= root_in;
         rad_ff     <= rad_in;
      end
   end

   assign dn_carry = carry_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;

endmodule

// ===== hdl/tfn_div_cell.sv =====
// tfn_div_cell: one quotient bit of a restoring divide, three lanes sharing a divisor
// depends on tfn_pkg

module tfn_div_cell #(
   parameter int unsigned SHIFT = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  tfn_pkg::tag_type                       up_tag,
   input  logic [tfn_pkg::LEN_W-1:0]              up_len,
   input  logic [2:0][tfn_pkg::DIV_W-1:0]         up_rem,
   input  logic [2:0][tfn_pkg::QUO_BITS-1:0]      up_quo,
   output tfn_pkg::tag_type                       dn_tag,
   output logic [tfn_pkg::LEN_W-1:0]              dn_len,
   output logic [2:0][tfn_pkg::DIV_W-1:0]         dn_rem,
   output logic [2:0][tfn_pkg::QUO_BITS-1:0]      dn_quo
);

   logic [tfn_pkg::DIV_W-1:0]              divisor;
   logic [2:0]                             take;
   logic [2:0][tfn_pkg::DIV_W-1:0]         rem_in, rem_ff;
   logic [2:0][tfn_pkg::QUO_BITS-1:0]      quo_in, quo_ff;
   logic [tfn_pkg::LEN_W-1:0]              len_ff;
   tfn_pkg::tag_type                       tag_ff;

   // compare against the shifted divisor, subtract when it fits
   always_comb begin
      divisor = tfn_pkg::DIV_W'(up_len) << SHIFT;
      for (int i = 0; i < 3; i++) begin
         take[i]   = (up_rem[i] >= divisor);
         rem_in[i] = take[i] ? (up_rem[i] - divisor) : up_rem[i];
         quo_in[i] = {up_quo[i][tfn_pkg::QUO_BITS-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= up_tag;
      end
      if (advance) begin
         len_ff <= up_len;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign dn_tag = tag_ff;
   assign dn_len = len_ff;
   assign dn_rem = rem_ff;
   assign dn_quo = quo_ff;

endmodule

// ===== hdl/triangle_face_normal_unit.sv =====
// triangle_face_normal_unit: top level of the triangle unit face normal pipeline
// depends on tfn_pkg, tfn_norm_cell, tfn_sqrt_cell, tfn_div_cell
//
// Usage: each req word is one triangle (a, b, c in signed Q16.16). Each rsp word
// is the unit normal of (c-b)x(a-b) in signed Q1.14, saturated to +-1.0, plus a
// degenerate flag when the cross product is exactly zero (normal is then zero).
// Both channels use valid/stall; a word moves when valid is high and stall low.
// A new triangle is taken every cycle unless the pipeline holds: the whole
// pipeline (edge and cross stages, a 7-cell normalize shifter, a 32-cell
// square root and a 15-cell divider) moves by one stage per cycle. The
// pipeline holds while the output register has a word and rsp_stall is high;
// req_stall is raised in exactly those cycles. While it holds, nothing inside
// changes and the output word stays put.
// Reset (synchronous, active high) drops every word in flight; rsp_valid falls
// and req_stall is low from the next cycle on.

module triangle_face_normal_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tfn_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tfn_pkg::rsp_type  rsp_data
);

   localparam int unsigned CB = tfn_pkg::COORD_BITS;
   localparam int unsigned NS = tfn_pkg::NORM_STEPS;
   localparam int unsigned SS = tfn_pkg::LEN_W;
   localparam int unsigned DS = tfn_pkg::QUO_BITS;

   logic advance;

   logic [2:0][CB-1:0] va, vb, vc;

   logic                                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0][tfn_pkg::EDGE_W-1:0]      e1_in, f1_in, e1_ff, f1_ff;
   logic [2:0][CB-1:0]                   em2_in, fm2_in, em2_ff, fm2_ff;
   logic [2:0]                           es2_in, fs2_in, es2_ff, fs2_ff;
   logic [2:0][1:0][tfn_pkg::PROD_W-1:0] prod3_in, prod3_ff;
   logic [2:0][1:0]                      psg3_in, psg3_ff;
   logic [2:0][tfn_pkg::P_W-1:0]         p4_in, p4_ff;
   tfn_pkg::tag_type                     tag5_in, tag5_ff;
   logic [2:0][tfn_pkg::MAG_W-1:0]       mag5_in, mag5_ff;

   tfn_pkg::tag_type                     nrm_tag [NS+1];
   logic [2:0][tfn_pkg::MAG_W-1:0]       nrm_mag [NS+1];

   tfn_pkg::sqc_type                     carry6_in, carry6_ff;
   logic [2:0][tfn_pkg::SQ_W-1:0]        sq6_in, sq6_ff;
   tfn_pkg::sqc_type                     carry7_ff;
   logic [tfn_pkg::SUM_W-1:0]            sum7_in, sum7_ff;

   tfn_pkg::sqc_type                     sq_carry [SS+1];
   logic [tfn_pkg::SQ_REM_W-1:0]         sq_rem   [SS+1];
   logic [tfn_pkg::LEN_W-1:0]            sq_root  [SS+1];
   logic [tfn_pkg::SUM_W-1:0]            sq_rad   [SS+1];

   tfn_pkg::tag_type                     tag8_ff;
   logic [tfn_pkg::LEN_W-1:0]            len8_ff;
   logic [2:0][tfn_pkg::DIV_W-1:0]       dvd8_in, dvd8_ff;

   tfn_pkg::tag_type                     dv_tag [DS+1];
   logic [tfn_pkg::LEN_W-1:0]            dv_len [DS+1];
   logic [2:0][tfn_pkg::DIV_W-1:0]       dv_rem [DS+1];
   logic [2:0][tfn_pkg::QUO_BITS-1:0]    dv_quo [DS+1];

   logic                                 rsp_valid_ff;
   tfn_pkg::rsp_type                     rsp_in, rsp_ff;

   // global pipeline enable
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign va = {req_data.az, req_data.ay,       req_data.ax};
   assign vb = {req_data.bz, req_data.by_coord, req_data.bx};
   assign vc = {req_data.cz, req_data.cy,       req_data.cx};

   // edges c-b and a-b, exact
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = {vc[i][CB-1], vc[i]} - {vb[i][CB-1], vb[i]};
         f1_in[i] = {va[i][CB-1], va[i]} - {vb[i][CB-1], vb[i]};
      end
   end

   // edge signs and magnitudes (magnitude always fits in a coordinate width)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         es2_in[i] = e1_ff[i][tfn_pkg::EDGE_W-1];
         fs2_in[i] = f1_ff[i][tfn_pkg::EDGE_W-1];
         em2_in[i] = es2_in[i] ? CB'(-e1_ff[i]) : CB'(e1_ff[i]);
         fm2_in[i] = fs2_in[i] ? CB'(-f1_ff[i]) : CB'(f1_ff[i]);
      end
   end

   // six unsigned partial products of the cross product
   always_comb begin
      int j, k;
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         k = (i == 0) ? 2 : i - 1;
         prod3_in[i][0] = tfn_pkg::PROD_W'(em2_ff[j]) * tfn_pkg::PROD_W'(fm2_ff[k]);
         prod3_in[i][1] = tfn_pkg::PROD_W'(em2_ff[k]) * tfn_pkg::PROD_W'(fm2_ff[j]);
         psg3_in[i][0]  = es2_ff[j] ^ fs2_ff[k];
         psg3_in[i][1]  = es2_ff[k] ^ fs2_ff[j];
      end
   end

   // signed cross components
   always_comb begin
      logic [tfn_pkg::P_W-1:0] t0, t1;
      for (int i = 0; i < 3; i++) begin
         t0 = tfn_pkg::P_W'(prod3_ff[i][0]);
         t1 = tfn_pkg::P_W'(prod3_ff[i][1]);
         if (psg3_ff[i][0]) t0 = -t0;
         if (psg3_ff[i][1]) t1 = -t1;
         p4_in[i] = t0 - t1;
      end
   end

   // component magnitudes, signs and the zero check
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tag5_in.neg[i] = p4_ff[i][tfn_pkg::P_W-1];
         mag5_in[i] = tag5_in.neg[i] ? tfn_pkg::MAG_W'(-p4_ff[i])
                                     : tfn_pkg::MAG_W'(p4_ff[i]);
      end
      tag5_in.valid      = v4_ff;
      tag5_in.degenerate = (mag5_in == '0);
   end

   // front stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         tag5_ff      <= '0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         tag5_ff      <= tag5_in;
      end
      if (advance) begin
         e1_ff    <= e1_in;
         f1_ff    <= f1_in;
         em2_ff   <= em2_in;
         fm2_ff   <= fm2_in;
         es2_ff   <= es2_in;
         fs2_ff   <= fs2_in;
         prod3_ff <= prod3_in;
         psg3_ff  <= psg3_in;
         p4_ff    <= p4_in;
         mag5_ff  <= mag5_in;
      end
   end

   // block normalize: bring the top set bit of the largest magnitude to the msb
   assign nrm_tag[0] = tag5_ff;
   assign nrm_mag[0] = mag5_ff;

   for (genvar g = 0; g < NS; g++) begin : g_norm
      tfn_norm_cell #(
         .SHIFT (1 << (NS - 1 - g))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tag  (nrm_tag[g]),
         .up_mag  (nrm_mag[g]),
         .dn_tag  (nrm_tag[g+1]),
         .dn_mag  (nrm_mag[g+1])
      );
   end

   // top bits become the scaled components; square them
   always_comb begin
      carry6_in.tag = nrm_tag[NS];
      for (int i = 0; i < 3; i++) begin
         carry6_in.r[i] = nrm_mag[NS][i][tfn_pkg::MAG_W-1 -: tfn_pkg::R_BITS];
         sq6_in[i] = tfn_pkg::SQ_W'(carry6_in.r[i]) * tfn_pkg::SQ_W'(carry6_in.r[i]);
      end
   end

   // sum of squares
   assign sum7_in = tfn_pkg::SUM_W'(sq6_ff[0]) + tfn_pkg::SUM_W'(sq6_ff[1])
                  + tfn_pkg::SUM_W'(sq6_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         carry6_ff.tag <= '0;
         carry7_ff.tag <= '0;
      end else if (advance) begin
         carry6_ff.tag <= carry6_in.tag;
         carry7_ff.tag <= carry6_ff.tag;
      end
      if (advance) begin
         carry6_ff.r <= carry6_in.r;
         carry7_ff.r <= carry6_ff.r;
         sq6_ff      <= sq6_in;
         sum7_ff     <= sum7_in;
      end
   end

   // square root, one root bit per cell
   assign sq_carry[0] = carry7_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = sum7_ff;

   for (genvar g = 0; g < SS; g++) begin : g_sqrt
      tfn_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .up_carry (sq_carry[g]),
         .up_rem   (sq_rem[g]),
         .up_root  (sq_root[g]),
         .up_rad   (sq_rad[g]),
         .dn_carry (sq_carry[g+1]),
         .dn_rem   (sq_rem[g+1]),
         .dn_root  (sq_root[g+1]),
         .dn_rad   (sq_rad[g+1])
      );
   end

   // rounded dividends r*2^frac + len/2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvd8_in[i] = (tfn_pkg::DIV_W'(sq_carry[SS].r[i]) << tfn_pkg::FRAC_BITS)
                    + tfn_pkg::DIV_W'(sq_root[SS] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag8_ff <= '0;
      end else if (advance) begin
         tag8_ff <= sq_carry[SS].tag;
      end
      if (advance) begin
         len8_ff <= sq_root[SS];
         dvd8_ff <= dvd8_in;
      end
   end

   // divide, one quotient bit per cell, msb first
   assign dv_tag[0] = tag8_ff;
   assign dv_len[0] = len8_ff;
   assign dv_rem[0] = dvd8_ff;
   assign dv_quo[0] = '0;

   for (genvar g = 0; g < DS; g++) begin : g_div
      tfn_div_cell #(
         .SHIFT (DS - 1 - g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tag  (dv_tag[g]),
         .up_len  (dv_len[g]),
         .up_rem  (dv_rem[g]),
         .up_quo  (dv_quo[g]),
         .dn_tag  (dv_tag[g+1]),
         .dn_len  (dv_len[g+1]),
         .dn_rem  (dv_rem[g+1]),
         .dn_quo  (dv_quo[g+1])
      );
   end

   // saturate to 1.0, apply sign, zero out a degenerate triangle
   always_comb begin
      logic [tfn_pkg::QUO_BITS-1:0]    n;
      logic [tfn_pkg::NORMAL_BITS-1:0] v [3];
      for (int i = 0; i < 3; i++) begin
         n = dv_quo[DS][i];
         if (n > (tfn_pkg::QUO_BITS'(1) << tfn_pkg::FRAC_BITS)) begin
            n = tfn_pkg::QUO_BITS'(1) << tfn_pkg::FRAC_BITS;
         end
         v[i] = tfn_pkg::NORMAL_BITS'(n);
         if (dv_tag[DS].neg[i]) v[i] = -v[i];
         if (dv_tag[DS].degenerate) v[i] = '0;
      end
      rsp_in.nx         = v[0];
      rsp_in.ny         = v[1];
      rsp_in.nz         = v[2];
      rsp_in.degenerate = dv_tag[DS].degenerate;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_tag[DS].valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a degenerate word carries a zero normal
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.nx == '0 && rsp_data.ny == '0 && rsp_data.nz == '0)
      else $error("degenerate word with nonzero normal");

   // a real normal is never all zero
   a_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         rsp_data.nx != '0 || rsp_data.ny != '0 || rsp_data.nz != '0)
      else $error("nondegenerate word with zero normal");

   // components stay within +-1.0
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_data.nx) <= $signed(16'sd16384) &&
         $signed(rsp_data.nx) >= $signed(-16'sd16384) &&
         $signed(rsp_data.ny) <= $signed(16'sd16384) &&
         $signed(rsp_data.ny) >= $signed(-16'sd16384) &&
         $signed(rsp_data.nz) <= $signed(16'sd16384) &&
         $signed(rsp_data.nz) >= $signed(-16'sd16384))
      else $error("normal component out of range");

   // a held output word freezes the input side
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output held");

endmodule
